// ===== rtl/core/wrcs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the weighted random child select unit.
// Holds shared widths, defaults and the cell control struct; no dependencies.
package wrcs_pkg;

  localparam int unsigned NUM_CHILDREN_DEF = 8;
  localparam int unsigned WEIGHT_BITS_DEF  = 8;
  localparam int unsigned RANDOM_BITS_DEF  = 16;

  // Fixed field widths of the ports
  localparam int unsigned REG_COUNT   = 8;
  localparam int unsigned REG_W       = 8;
  localparam int unsigned REG_IDX_W   = 3;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned CHILD_IDX_W = 3;

  localparam logic [REG_W-1:0] WEIGHT_RESET = REG_W'(1);

  // Control that travels with a word down the chain of cells
  typedef struct packed {
    logic vld;   // word present in this stage
    logic any;   // some eligible child seen so far
    logic done;  // running total has reached the threshold
  } cell_ctrl_t;

endpackage

// ===== rtl/core/wrcs_front.sv =====
`timescale 1ns / 1ps
// Front end: eligible weight sum, then sum times fraction to a threshold.
// Depends on wrcs_pkg.
module wrcs_front #(
  parameter int unsigned NUM_CHILDREN = wrcs_pkg::NUM_CHILDREN_DEF,
  parameter int unsigned WEIGHT_BITS  = wrcs_pkg::WEIGHT_BITS_DEF,
  parameter int unsigned RANDOM_BITS  = wrcs_pkg::RANDOM_BITS_DEF,
  parameter int unsigned SUM_W        = WEIGHT_BITS + $clog2(NUM_CHILDREN)
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    acc_i,
  input  logic [wrcs_pkg::MASK_W-1:0]             mask_i,
  input  logic [wrcs_pkg::FRAC_W-1:0]             frac_i,
  input  logic [NUM_CHILDREN-1:0][WEIGHT_BITS-1:0] weight_i,
  output logic                                    vld_o,
  output logic [wrcs_pkg::MASK_W-1:0]             mask_o,
  output logic [SUM_W-1:0]                        thr_o
);

  localparam int unsigned FRAC_EXT_W =
    (RANDOM_BITS > wrcs_pkg::FRAC_W) ? RANDOM_BITS : wrcs_pkg::FRAC_W;
  localparam int unsigned PROD_W = SUM_W + RANDOM_BITS;

  logic                          sum_vld_q;
  logic [wrcs_pkg::MASK_W-1:0]   sum_mask_q;
  logic [RANDOM_BITS-1:0]        sum_frac_q;
  logic [SUM_W-1:0]              sum_q;
  logic [SUM_W-1:0]              sum_d;
  logic [FRAC_EXT_W-1:0]         frac_ext;
  logic [PROD_W-1:0]             prod;
  logic                          thr_vld_q;
  logic [wrcs_pkg::MASK_W-1:0]   thr_mask_q;
  logic [SUM_W-1:0]              thr_q;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NUM_CHILDREN; i++) begin
      if (mask_i[i]) begin
        sum_d = sum_d + SUM_W'(weight_i[i]);
      end
    end
  end

  assign frac_ext = FRAC_EXT_W'(frac_i);
  assign prod     = PROD_W'(sum_q) * PROD_W'(sum_frac_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
      thr_vld_q <= 1'b0;
    end else if (en_i) begin
      sum_vld_q <= acc_i;
      thr_vld_q <= sum_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_mask_q <= mask_i;
      sum_frac_q <= frac_ext[RANDOM_BITS-1:0];
      sum_q      <= sum_d;
      thr_mask_q <= sum_mask_q;
      // drop the fraction bits
      thr_q      <= prod[PROD_W-1:RANDOM_BITS];
    end
  end

  assign vld_o  = thr_vld_q;
  assign mask_o = thr_mask_q;
  assign thr_o  = thr_q;

endmodule

// ===== rtl/core/wrcs_cell.sv =====
`timescale 1ns / 1ps
// One cell of the chain: if eligible and not yet done, adds its child's weight
// to the total and claims the word; it is done at the threshold. Uses wrcs_pkg.
module wrcs_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned WEIGHT_BITS = wrcs_pkg::WEIGHT_BITS_DEF,
  parameter int unsigned SUM_W       = wrcs_pkg::WEIGHT_BITS_DEF + 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic [WEIGHT_BITS-1:0]             weight_i,
  input  wrcs_pkg::cell_ctrl_t               ctrl_i,
  input  logic [wrcs_pkg::MASK_W-1:0]        mask_i,
  input  logic [SUM_W-1:0]                   thr_i,
  input  logic [SUM_W-1:0]                   run_i,
  input  logic [wrcs_pkg::CHILD_IDX_W-1:0]   pick_i,
  output wrcs_pkg::cell_ctrl_t               ctrl_o,
  output logic [wrcs_pkg::MASK_W-1:0]        mask_o,
  output logic [SUM_W-1:0]                   thr_o,
  output logic [SUM_W-1:0]                   run_o,
  output logic [wrcs_pkg::CHILD_IDX_W-1:0]   pick_o
);

  wrcs_pkg::cell_ctrl_t              ctrl_d, ctrl_q;
  logic [SUM_W-1:0]                  run_d, run_q, run_sum;
  logic [wrcs_pkg::CHILD_IDX_W-1:0]  pick_d, pick_q;
  logic [wrcs_pkg::MASK_W-1:0]       mask_q;
  logic [SUM_W-1:0]                  thr_q;
  logic                              take;

  assign take    = mask_i[IDX] && !ctrl_i.done;
  assign run_sum = run_i + SUM_W'(weight_i);

  always_comb begin
    ctrl_d     = ctrl_i;
    run_d      = run_i;
    pick_d     = pick_i;
    ctrl_d.any = ctrl_i.any | mask_i[IDX];
    if (take) begin
      run_d       = run_sum;
      pick_d      = wrcs_pkg::CHILD_IDX_W'(IDX);
      ctrl_d.done = (run_sum >= thr_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mask_q <= mask_i;
      thr_q  <= thr_i;
      run_q  <= run_d;
      pick_q <= pick_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign mask_o = mask_q;
  assign thr_o  = thr_q;
  assign run_o  = run_q;
  assign pick_o = pick_q;

endmodule

// ===== rtl/core/weighted_random_child_select_unit.sv =====
`timescale 1ns / 1ps
// Weighted random child select unit: roulette wheel pick over eligible children.
// Stages from accepted word to result: sum stage, multiply stage, one cell per
// child. Throughput: one word per cycle; the whole pipe holds while the output
// word is stalled.
// Reset: pipe empties, every weight register returns to 1.
module weighted_random_child_select_unit #(
  parameter int unsigned NUM_CHILDREN = wrcs_pkg::NUM_CHILDREN_DEF,
  parameter int unsigned WEIGHT_BITS  = wrcs_pkg::WEIGHT_BITS_DEF,
  parameter int unsigned RANDOM_BITS  = wrcs_pkg::RANDOM_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wrcs_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wrcs_pkg::REG_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [wrcs_pkg::MASK_W-1:0]        eligible_mask_i,
  input  logic [wrcs_pkg::FRAC_W-1:0]        random_fraction_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [wrcs_pkg::CHILD_IDX_W-1:0]   chosen_child_o,
  output logic                               no_eligible_o
);

  localparam int unsigned SUM_W = WEIGHT_BITS + $clog2(NUM_CHILDREN);
  localparam int unsigned W_EXT_W =
    (WEIGHT_BITS > wrcs_pkg::REG_W) ? WEIGHT_BITS : wrcs_pkg::REG_W;

  logic [wrcs_pkg::REG_W-1:0]        weight_q [wrcs_pkg::REG_COUNT];
  logic [NUM_CHILDREN-1:0][WEIGHT_BITS-1:0] weight;
  logic [W_EXT_W-1:0]                weight_ext [NUM_CHILDREN];

  logic                              en;
  logic                              acc;

  wrcs_pkg::cell_ctrl_t              ctrl_w [NUM_CHILDREN+1];
  logic [wrcs_pkg::MASK_W-1:0]       mask_w [NUM_CHILDREN+1];
  logic [SUM_W-1:0]                  thr_w  [NUM_CHILDREN+1];
  logic [SUM_W-1:0]                  run_w  [NUM_CHILDREN+1];
  logic [wrcs_pkg::CHILD_IDX_W-1:0]  pick_w [NUM_CHILDREN+1];
  logic                              front_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wrcs_pkg::REG_COUNT; i++) begin
        weight_q[i] <= wrcs_pkg::WEIGHT_RESET;
      end
    end else if (cfg_we_i) begin
      weight_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // keep the low WEIGHT_BITS of each register, zero-extend when wider
  for (genvar g = 0; g < NUM_CHILDREN; g++) begin : g_weight
    assign weight_ext[g] = W_EXT_W'(weight_q[g]);
    assign weight[g]     = weight_ext[g][WEIGHT_BITS-1:0];
  end

  // advance the whole pipe unless the output word is held
  assign en          = !ctrl_w[NUM_CHILDREN].vld || !out_stall_i;
  assign in_stall_o  = !en;
  assign acc         = in_valid_i && en;

  wrcs_front #(
    .NUM_CHILDREN (NUM_CHILDREN),
    .WEIGHT_BITS  (WEIGHT_BITS),
    .RANDOM_BITS  (RANDOM_BITS),
    .SUM_W        (SUM_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .acc_i    (acc),
    .mask_i   (eligible_mask_i),
    .frac_i   (random_fraction_i),
    .weight_i (weight),
    .vld_o    (front_vld),
    .mask_o   (mask_w[0]),
    .thr_o    (thr_w[0])
  );

  always_comb begin
    ctrl_w[0]      = '0;
    ctrl_w[0].vld  = front_vld;
  end
  assign run_w[0]  = '0;
  assign pick_w[0] = '0;

  for (genvar c = 0; c < NUM_CHILDREN; c++) begin : g_cell
    wrcs_cell #(
      .IDX         (c),
      .WEIGHT_BITS (WEIGHT_BITS),
      .SUM_W       (SUM_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .weight_i (weight[c]),
      .ctrl_i   (ctrl_w[c]),
      .mask_i   (mask_w[c]),
      .thr_i    (thr_w[c]),
      .run_i    (run_w[c]),
      .pick_i   (pick_w[c]),
      .ctrl_o   (ctrl_w[c+1]),
      .mask_o   (mask_w[c+1]),
      .thr_o    (thr_w[c+1]),
      .run_o    (run_w[c+1]),
      .pick_o   (pick_w[c+1])
    );
  end

  // pick stays zero when no cell claimed the word
  assign out_valid_o    = ctrl_w[NUM_CHILDREN].vld;
  assign chosen_child_o = pick_w[NUM_CHILDREN];
  assign no_eligible_o  = !ctrl_w[NUM_CHILDREN].any;

  a_empty_pick_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_eligible_o |-> chosen_child_o == '0)
    else $error("empty mask gave a nonzero child");

  a_pick_eligible : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !no_eligible_o |-> mask_w[NUM_CHILDREN][chosen_child_o])
    else $error("chosen child is not eligible");

  a_flag_matches_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> no_eligible_o == (mask_w[NUM_CHILDREN][NUM_CHILDREN-1:0] == '0))
    else $error("no-eligible flag disagrees with mask");

  a_stall_only_on_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output is free");

endmodule
